// ----- src/firrs_pkg.sv -----
package firrs_pkg;

	// One input request
	typedef struct packed {
		logic signed [15:0] sample_in;
		logic               block_start;
	} smp_t;

	// One result request
	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               last;
	} res_t;

	// Register indexes
	localparam logic [7:0] REG_MODE    = 8'd0;
	localparam logic [7:0] REG_FACTOR  = 8'd1;
	localparam logic [7:0] REG_TAP_SET = 8'd2;
	localparam logic [7:0] REG_GAIN    = 8'd3;

	// Mode codes
	localparam logic MODE_INTERP = 1'b0;
	localparam logic MODE_DECIM  = 1'b1;

	// Tap index width: longest table has 128 taps
	localparam int TAP_W = 7;

	localparam logic signed [15:0] C9 [0:8] = '{
		-16'sd431, 16'sd1780, -16'sd4076, 16'sd6400, 16'sd25374, 16'sd6400,
		-16'sd4076, 16'sd1780, -16'sd431
	};

	localparam logic signed [15:0] C15 [0:14] = '{
		16'sd159, 16'sd467, 16'sd32, -16'sd1768, -16'sd2511, 16'sd1767,
		16'sd9859, 16'sd14140, 16'sd9859, 16'sd1767, -16'sd2511, -16'sd1768,
		16'sd32, 16'sd467, 16'sd159
	};

	localparam logic signed [15:0] C31 [0:30] = '{
		16'sd20, 16'sd66, 16'sd132, 16'sd179, 16'sd137, -16'sd69, -16'sd457,
		-16'sd937, -16'sd1294, -16'sd1235, -16'sd514, 16'sd935, 16'sd2906,
		16'sd4943, 16'sd6481, 16'sd7053, 16'sd6481, 16'sd4943, 16'sd2906,
		16'sd935, -16'sd514, -16'sd1235, -16'sd1294, -16'sd937, -16'sd457,
		-16'sd69, 16'sd137, 16'sd179, 16'sd132, 16'sd66, 16'sd20
	};

	// First half of the symmetric 128-tap table
	localparam logic signed [15:0] C128H [0:63] = '{
		-16'sd13, -16'sd45, -16'sd95, -16'sd147, -16'sd167, -16'sd124,
		-16'sd13, 16'sd132, 16'sd245, 16'sd268, 16'sd190, 16'sd61, -16'sd36,
		-16'sd38, 16'sd47, 16'sd148, 16'sd178, 16'sd105, -16'sd19, -16'sd96,
		-16'sd62, 16'sd59, 16'sd165, 16'sd160, 16'sd36, -16'sd111, -16'sd156,
		-16'sd52, 16'sd124, 16'sd220, 16'sd143, -16'sd59, -16'sd221,
		-16'sd194, 16'sd16, 16'sd242, 16'sd283, 16'sd81, -16'sd212, -16'sd345,
		-16'sd180, 16'sd171, 16'sd414, 16'sd318, -16'sd76, -16'sd453,
		-16'sd469, -16'sd58, 16'sd471, 16'sd654, 16'sd266, -16'sd438,
		-16'sd868, -16'sd571, 16'sd336, 16'sd1148, 16'sd1075, -16'sd83,
		-16'sd1591, -16'sd2121, -16'sd628, 16'sd2824, 16'sd6888, 16'sd9620
	};

	// Index of the last tap of a table
	function automatic logic [TAP_W-1:0] tap_last(input logic [1:0] ts);
		logic [TAP_W-1:0] r;
		unique case (ts)
			2'd0: r = 7'd8;
			2'd1: r = 7'd14;
			2'd2: r = 7'd30;
			default: r = 7'd127;
		endcase
		return r;
	endfunction

	// Coefficient j of a table, zero past its end
	function automatic logic signed [15:0] coef_at(input logic [1:0] ts,
			input logic [TAP_W-1:0] j);
		logic signed [15:0] r;
		unique case (ts)
			2'd0: r = (j < 7'd9) ? C9[j[3:0]] : 16'sd0;
			2'd1: r = (j < 7'd15) ? C15[j[3:0]] : 16'sd0;
			2'd2: r = (j < 7'd31) ? C31[j[4:0]] : 16'sd0;
			default: r = j[6] ? C128H[~j[5:0]] : C128H[j[5:0]];
		endcase
		return r;
	endfunction

endpackage

// ----- src/fir_integer_resampler_top.sv -----
// Integer-factor FIR resampler.
// Input channel smp (smp_valid / smp_stall): one 16-bit sample with a block
// start flag per request. Result channel res (res_valid / res_stall): one
// filtered sample per request, last set on the final result of an input.
// Config channel cfg (cfg_valid / cfg_ready, always ready): index 0 mode,
// 1 factor, 2 tap_set, 3 gain; write only while no input is in flight.
// One signed 17x17 multiplier is shared: multiply-accumulate over the
// T taps of the table, then three gain partial products. In interpolate
// mode an input runs factor MAC passes, one per result; in decimate mode
// it runs one pass on phase zero and none on other phases. smp_stall is
// high while an input is being worked. The result register holds one
// result; a stalled receiver holds the sequencer before it loads the next
// result, and a new input is taken while the final result still waits.
// Reset clears the window through a fill count (unfilled taps read zero),
// the phase, the handshakes and the registers to mode 0, factor 2,
// tap_set 0, gain 256. No clearing pass is needed.
module fir_integer_resampler_top #(
	parameter int MAX_TAPS   = 128,
	parameter int MAX_FACTOR = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               smp_valid,
	output logic               smp_stall,
	input  firrs_pkg::smp_t    smp,
	output logic               res_valid,
	input  logic               res_stall,
	output firrs_pkg::res_t    res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int AW  = $clog2(MAX_TAPS);
	localparam int FLW = $clog2(MAX_TAPS + 1);
	localparam int LW  = (FLW > firrs_pkg::TAP_W) ? FLW : firrs_pkg::TAP_W;
	localparam int FW  = $clog2(MAX_FACTOR + 1);
	localparam int PW  = $clog2(MAX_FACTOR);
	localparam int CW  = (FW > 4) ? FW : 4;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PUSH   = 7'b0000010,
		ST_MAC    = 7'b0000100,
		ST_DRAIN  = 7'b0001000,
		ST_SCALE  = 7'b0010000,
		ST_SDRAIN = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	state_t state_q;

	logic        mode_q;
	logic [3:0]  factor_q;
	logic [1:0]  tap_set_q;
	logic [15:0] gain_q;

	logic [AW-1:0]  head_q, head_next, raddr_q;
	logic [FLW-1:0] fill_q;
	logic [PW-1:0]  phase_q, rem_q;
	logic [firrs_pkg::TAP_W-1:0] cnt_q, tlast;
	logic [1:0]     k_q;

	logic signed [15:0] win_mem [MAX_TAPS];
	logic               wr_en;
	logic signed [15:0] wr_data;

	logic               mac_s1, sc_s1, live_s1, mac_s2, sc_s2;
	logic signed [15:0] rd_s1, coef_s1;
	logic [15:0]        chunk_s1;
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] prod_s2;

	logic signed [39:0] acc_q;
	logic [39:0]        mag_q;
	logic               neg_q;
	logic [55:0]        p_q;

	logic        smp_acc, res_load, produce;
	logic [CW-1:0] fac_w;
	logic [FW-1:0] fe;
	logic [PW-1:0] ph;
	logic [PW:0]   ph_inc;
	logic [32:0]   qv;
	logic signed [15:0] sat;

	assign cfg_ready = 1'b1;
	assign smp_stall = (state_q != ST_IDLE);
	assign smp_acc   = smp_valid && !smp_stall;
	assign res_load  = (state_q == ST_OUT) && (!res_valid || !res_stall);
	assign tlast     = firrs_pkg::tap_last(tap_set_q);

	// Effective factor: zero acts as one, clamp at the maximum
	always_comb begin
		fac_w = CW'(factor_q);
		priority if (fac_w == '0) fe = FW'(1);
		else if (fac_w > CW'(MAX_FACTOR)) fe = FW'(MAX_FACTOR);
		else fe = FW'(fac_w);
	end

	// Decimation phase for the incoming sample
	assign ph      = smp.block_start ? '0 : phase_q;
	assign ph_inc  = (PW + 1)'(ph) + (PW + 1)'(1);
	assign produce = (mode_q == firrs_pkg::MODE_INTERP) || (ph == '0);

	assign head_next = (head_q == AW'(MAX_TAPS - 1)) ? '0 : head_q + AW'(1);

	// Window write: new sample on accept, zero stuffing between results
	assign wr_en   = smp_acc || (state_q == ST_PUSH);
	assign wr_data = (state_q == ST_PUSH) ? 16'sd0 : smp.sample_in;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= firrs_pkg::MODE_INTERP;
			factor_q  <= 4'd2;
			tap_set_q <= 2'd0;
			gain_q    <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				firrs_pkg::REG_MODE:    mode_q    <= cfg_data[0];
				firrs_pkg::REG_FACTOR:  factor_q  <= cfg_data[3:0];
				firrs_pkg::REG_TAP_SET: tap_set_q <= cfg_data[1:0];
				firrs_pkg::REG_GAIN:    gain_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) win_mem[head_next] <= wr_data;
		rd_s1 <= win_mem[raddr_q];
	end

	// Shared multiplier operands; unfilled taps feed a zero sample
	always_comb begin
		if (sc_s1) begin
			mul_a = {1'b0, chunk_s1};
			mul_b = {1'b0, gain_q};
		end else begin
			mul_a = live_s1 ? {rd_s1[15], rd_s1} : 17'sd0;
			mul_b = {coef_s1[15], coef_s1};
		end
	end

	// Operand and product stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			sc_s1  <= 1'b0;
			mac_s2 <= 1'b0;
			sc_s2  <= 1'b0;
		end else begin
			mac_s1 <= (state_q == ST_MAC);
			sc_s1  <= (state_q == ST_SCALE);
			mac_s2 <= mac_s1;
			sc_s2  <= sc_s1;
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= firrs_pkg::coef_at(tap_set_q, tlast - cnt_q);
		live_s1 <= LW'(cnt_q) < LW'(fill_q);
		unique case (k_q)
			2'd2:    chunk_s1 <= {8'd0, mag_q[39:32]};
			2'd1:    chunk_s1 <= mag_q[31:16];
			default: chunk_s1 <= mag_q[15:0];
		endcase
		prod_s2 <= mul_a * mul_b;
	end

	// Saturated result from the scaled magnitude
	always_comb begin
		qv = p_q[55:23];
		if (neg_q) sat = (qv > 33'd32768) ? -16'sd32768 : 16'(~qv + 33'd1);
		else       sat = (qv > 33'd32767) ? 16'sd32767 : 16'(qv);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			fill_q  <= '0;
			phase_q <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
			raddr_q <= '0;
		end else begin
			if (wr_en) begin
				head_q  <= head_next;
				raddr_q <= head_next;
				cnt_q   <= '0;
				if (fill_q != FLW'(MAX_TAPS)) fill_q <= fill_q + FLW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (smp_acc) begin
						rem_q <= (mode_q == firrs_pkg::MODE_INTERP) ?
							PW'(fe - FW'(1)) : '0;
						if (mode_q == firrs_pkg::MODE_DECIM)
							phase_q <= (ph_inc >= (PW + 1)'(fe)) ? '0 : PW'(ph_inc);
						else
							phase_q <= ph;
						if (produce) state_q <= ST_MAC;
					end
				end
				ST_PUSH: state_q <= ST_MAC;
				ST_MAC: begin
					cnt_q   <= cnt_q + 1'b1;
					raddr_q <= (raddr_q == '0) ? AW'(MAX_TAPS - 1) : raddr_q - AW'(1);
					if (cnt_q == tlast) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!mac_s1 && !mac_s2) begin
						k_q     <= 2'd2;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					k_q <= k_q - 2'd1;
					if (k_q == 2'd0) state_q <= ST_SDRAIN;
				end
				ST_SDRAIN: begin
					if (!sc_s1 && !sc_s2) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_load) begin
						if (rem_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rem_q   <= rem_q - PW'(1);
							state_q <= ST_PUSH;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Accumulate filter sum, then gain partial products (high chunk first)
	always_ff @(posedge clk) begin
		if (wr_en) acc_q <= '0;
		else if (mac_s2) acc_q <= acc_q + 40'(prod_s2);
		if (state_q == ST_DRAIN) begin
			neg_q <= acc_q[39];
			mag_q <= acc_q[39] ? 40'(-acc_q) : 40'(acc_q);
			p_q   <= '0;
		end else if (sc_s2) begin
			p_q <= {p_q[39:0], 16'd0} + 56'(prod_s2[31:0]);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else if (res_load) res_valid <= 1'b1;
		else if (!res_stall) res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res.sample_out <= sat;
			res.last       <= (rem_q == '0);
		end
	end

	// Checks
	a_rose_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_OUT))
		else $error("result shown without an output step");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FLW'(MAX_TAPS))
		else $error("fill count past window depth");

	a_scale_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCALE) |-> !mac_s1 && !mac_s2)
		else $error("gain pass overlaps filter sum");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && rem_q == '0) |=> state_q == ST_IDLE && res.last)
		else $error("final result did not release the input");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(PW + 1)'(phase_q) < (PW + 1)'(MAX_FACTOR))
		else $error("phase beyond maximum factor");

endmodule

// ----- tb/fir_resampler_checker.sv -----
module fir_resampler_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            smp_valid,
	input  logic            smp_stall,
	input  firrs_pkg::smp_t smp,
	input  logic            res_valid,
	input  logic            res_stall,
	input  firrs_pkg::res_t res,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic [7:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	output int              fail_count,
	output int              pending,
	output int              samples_seen,
	output int              results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_DEPTH = 128;
	localparam int MAX_RATIO = 8;

	// Q1.15 low-pass tables
	localparam int TAPS9 [9] = '{
		-431, 1780, -4076, 6400, 25374, 6400, -4076, 1780, -431
	};
	localparam int TAPS15 [15] = '{
		159, 467, 32, -1768, -2511, 1767, 9859, 14140, 9859, 1767, -2511, -1768,
		32, 467, 159
	};
	localparam int TAPS31 [31] = '{
		20, 66, 132, 179, 137, -69, -457, -937, -1294, -1235, -514, 935, 2906,
		4943, 6481, 7053, 6481, 4943, 2906, 935, -514, -1235, -1294, -937, -457,
		-69, 137, 179, 132, 66, 20
	};
	// first half only, the long table is symmetric
	localparam int TAPS128H [64] = '{
		-13, -45, -95, -147, -167, -124, -13, 132, 245, 268, 190, 61, -36, -38,
		47, 148, 178, 105, -19, -96, -62, 59, 165, 160, 36, -111, -156, -52, 124,
		220, 143, -59, -221, -194, 16, 242, 283, 81, -212, -345, -180, 171, 414,
		318, -76, -453, -469, -58, 471, 654, 266, -438, -868, -571, 336, 1148,
		1075, -83, -1591, -2121, -628, 2824, 6888, 9620
	};

	// predicted block state
	logic               cur_mode;
	logic [3:0]         cur_factor;
	logic [1:0]         cur_taps;
	logic [15:0]        cur_gain;
	logic signed [15:0] hist [WIN_DEPTH];
	int                 dec_phase;

	firrs_pkg::res_t want_q [$];
	firrs_pkg::res_t due;
	int   fails;
	int   n_in;
	int   n_out;

	function automatic int tap_total(input logic [1:0] ts);
		case (ts)
			2'd0: return 9;
			2'd1: return 15;
			2'd2: return 31;
			default: return 128;
		endcase
	endfunction

	function automatic longint tap_coef(input logic [1:0] ts, input int j);
		case (ts)
			2'd0: return TAPS9[j];
			2'd1: return TAPS15[j];
			2'd2: return TAPS31[j];
			default: return (j < 64) ? TAPS128H[j] : TAPS128H[127 - j];
		endcase
	endfunction

	function automatic void shift_in(input logic signed [15:0] s);
		for (int i = WIN_DEPTH - 1; i > 0; i--)
			hist[i] = hist[i - 1];
		hist[0] = s;
	endfunction

	// FIR sum, gain, truncate toward zero, saturate
	function automatic logic [15:0] fir_output();
		int     t;
		longint acc;
		longint prod;
		longint mag;
		longint q;
		t = tap_total(cur_taps);
		acc = 0;
		for (int j = 0; j < t; j++)
			acc += tap_coef(cur_taps, j) * longint'(hist[t - 1 - j]);
		prod = acc * longint'(cur_gain);
		mag = (prod < 0) ? -prod : prod;
		q = mag >> 23;
		if (prod < 0) begin
			if (q > 32768) q = 32768;
			return 16'(-q);
		end
		if (q > 32767) q = 32767;
		return 16'(q);
	endfunction

	// queue the results one input request causes
	function automatic void predict(input firrs_pkg::smp_t req);
		int              f;
		firrs_pkg::res_t r;
		f = int'(cur_factor);
		if (f == 0) f = 1;
		if (f > MAX_RATIO) f = MAX_RATIO;
		if (req.block_start) dec_phase = 0;
		if (cur_mode == firrs_pkg::MODE_INTERP) begin
			for (int k = 0; k < f; k++) begin
				shift_in((k == 0) ? req.sample_in : 16'sd0);
				r.sample_out = fir_output();
				r.last = (k == f - 1);
				want_q.push_back(r);
			end
		end else begin
			shift_in(req.sample_in);
			if (dec_phase == 0) begin
				r.sample_out = fir_output();
				r.last = 1'b1;
				want_q.push_back(r);
			end
			dec_phase++;
			if (dec_phase >= f) dec_phase = 0;
		end
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fails++;
	endtask

	// config, result check, then prediction: a result seen at the same edge
	// as a new input always belongs to an older input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode = firrs_pkg::MODE_INTERP;
			cur_factor = 4'd2;
			cur_taps = 2'd0;
			cur_gain = 16'd256;
			for (int i = 0; i < WIN_DEPTH; i++)
				hist[i] = 16'sd0;
			dec_phase = 0;
			want_q.delete();
			fails = 0;
			n_in = 0;
			n_out = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					firrs_pkg::REG_MODE:    cur_mode = cfg_data[0];
					firrs_pkg::REG_FACTOR:  cur_factor = cfg_data[3:0];
					firrs_pkg::REG_TAP_SET: cur_taps = cfg_data[1:0];
					firrs_pkg::REG_GAIN:    cur_gain = cfg_data;
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				n_out++;
				if (want_q.size() == 0) begin
					report_error($sformatf("result %0d with nothing pending", res.sample_out));
				end else begin
					due = want_q.pop_front();
					if (res.sample_out !== due.sample_out)
						report_error($sformatf("result %0d sample_out %0d, want %0d",
							n_out, res.sample_out, due.sample_out));
					if (res.last !== due.last)
						report_error($sformatf("result %0d last %b, want %b",
							n_out, res.last, due.last));
				end
			end
			if (smp_valid && !smp_stall) begin
				n_in++;
				predict(smp);
			end
		end
		fail_count <= fails;
		pending <= want_q.size();
		samples_seen <= n_in;
		results_seen <= n_out;
	end

endmodule

// ----- tb/fir_integer_resampler_top_test.sv -----
module fir_integer_resampler_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	// longest correct quiet stretch is the idle pause plus one long MAC pass
	localparam int QUIET_LIMIT = 5000;
	localparam int IDLE_PAUSE  = 200;
	localparam int RAND_ITEMS  = 340;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            smp_valid = 1'b0;
	logic            smp_stall;
	firrs_pkg::smp_t smp = '0;
	logic            res_valid;
	logic            res_stall = 1'b0;
	firrs_pkg::res_t res;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [7:0]      cfg_index = '0;
	logic [15:0]     cfg_data = '0;

	int fail_count;
	int pending;
	int samples_seen;
	int results_seen;

	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	int rx_wait = 0;
	int quiet = 0;
	int settings_run = 0;

	fir_integer_resampler_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fir_resampler_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp_valid    (smp_valid),
		.smp_stall    (smp_stall),
		.smp          (smp),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.samples_seen (samples_seen),
		.results_seen (results_seen)
	);

	always #5 clk = ~clk;

	function automatic int draw_wait(input bit burst);
		if (burst) return 0;
		return $urandom_range(16, 0);
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(7, 0))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(31, 0)) - 16'd16;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(9, 0))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'd256;
			4, 5: return 16'($urandom_range(767, 64));
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver: stall for a drawn number of cycles after each result
	always @(posedge clk) begin
		int gap_n;
		if (res_valid && !res_stall) begin
			gap_n = draw_wait(rx_burst);
			rx_wait <= gap_n;
			res_stall <= (gap_n != 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			res_stall <= (rx_wait > 1);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// watchdog on cycles with no request moving on any channel
	always @(posedge clk) begin
		if ((smp_valid && !smp_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: %0d cycles with no request, %0d results pending",
				quiet, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_sample(input logic signed [15:0] s, input logic bs);
		int gap;
		gap = draw_wait(tx_burst);
		if (gap != 0) begin
			smp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp <= '{sample_in: s, block_start: bs};
		smp_valid <= 1'b1;
		do @(posedge clk); while (smp_stall);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// hold the sender until every predicted result is out
	task automatic drain();
		smp_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// no-result inputs may still be in flight once the queue is empty
	task automatic settle();
		drain();
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	// unused upper data bits are randomized, the block must ignore them
	task automatic configure(input logic m, input logic [3:0] f, input logic [1:0] ts,
			input logic [15:0] g);
		settle();
		write_reg(firrs_pkg::REG_MODE, {15'($urandom), m});
		write_reg(firrs_pkg::REG_FACTOR, {12'($urandom), f});
		write_reg(firrs_pkg::REG_TAP_SET, {14'($urandom), ts});
		write_reg(firrs_pkg::REG_GAIN, g);
		settings_run++;
	endtask

	initial begin
		int   rand_sent;
		int   n;
		int   blk_left;
		logic m;
		logic [3:0] f;
		logic [1:0] ts;
		logic bs;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: interpolate by 2, nine taps, unity gain;
		// block start in interpolate mode only clears the decimation phase
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b1);

		// decimate by 3 at full gain; both block starts fall on phase zero
		configure(firrs_pkg::MODE_DECIM, 4'd3, 2'd1, 16'hFFFF);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sd12345, 1'b0);
		send_sample(16'sh8000, 1'b0);

		// run the phase to 5 with factor 8, then shrink the factor below it
		configure(firrs_pkg::MODE_DECIM, 4'd8, 2'd2, 16'd0);
		repeat (5) send_sample(pick_sample(), 1'b0);
		configure(firrs_pkg::MODE_DECIM, 4'd3, 2'd2, 16'd128);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(-16'sd20000, 1'b0);

		// factor zero acts as one; long table reads a window kept across
		// the tap set change; stray register indexes are ignored
		configure(firrs_pkg::MODE_INTERP, 4'd0, 2'd3, 16'd300);
		write_reg(8'd4, 16'($urandom));
		write_reg(8'hFF, 16'hFFFF);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b1);

		// factor above the maximum clamps to eight
		configure(firrs_pkg::MODE_INTERP, 4'hF, 2'd0, 16'd256);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);

		configure(firrs_pkg::MODE_DECIM, 4'd1, 2'd3, 16'hFFFF);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 1'b0);

		// random settings, each with a run of blocked samples
		rand_sent = 0;
		blk_left = 0;
		while (rand_sent < RAND_ITEMS) begin
			m = 1'($urandom_range(1, 0));
			f = ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 0))
				: 4'($urandom_range(8, 1));
			ts = 2'($urandom_range(3, 0));
			// long table times big factor is slow, keep those runs short
			n = (ts == 2'd3 && m == firrs_pkg::MODE_INTERP) ? 6 : $urandom_range(40, 20);
			configure(m, f, ts, pick_gain());
			if ($urandom_range(3, 0) == 0)
				write_reg(8'($urandom_range(255, 4)), 16'($urandom));
			tx_burst = ($urandom_range(3, 0) == 0);
			rx_burst <= ($urandom_range(3, 0) == 0);
			for (int i = 0; i < n; i++) begin
				if (blk_left == 0) begin
					bs = 1'b1;
					blk_left = $urandom_range(12, 1);
				end else begin
					bs = ($urandom_range(9, 0) == 0);
				end
				blk_left--;
				send_sample(pick_sample(), bs);
				if (i == n / 2 || $urandom_range(49, 0) == 0)
					drain();
			end
			rand_sent += n;
		end

		settle();

		$display("run covered %0d input samples and %0d results over %0d settings",
			samples_seen, results_seen, settings_run);
		$display("both modes, factors 0..15, all four tables, gains 0..65535, saturation");
		if (pending != 0)
			$display("%0d predicted results never came out", pending);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
src/firrs_pkg.sv
src/fir_integer_resampler_top.sv
tb/fir_resampler_checker.sv
tb/fir_integer_resampler_top_test.sv
